[rtl/core/oqdk_pkg.sv]
`timescale 1ns / 1ps

package oqdk_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 22;
  localparam int TAG_BITS = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // opcodes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_LOOK = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic                bg;
  } entry_t;

  // match result handed along the chain, oldest cell first
  typedef struct packed {
    logic                hit;
    logic [TAG_BITS-1:0] tag;
    logic                bg;
  } fnd_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic   cmp;        // compare the search key against the stored key
    logic   apply;      // commit the update
    logic   enq_wr;     // enqueue accepted: tail cell loads the new entry
    logic   shift_all;  // dequeue: every cell takes its younger neighbor
    logic   shift_del;  // delete: cells from the first match on shift
    entry_t wr;         // new entry / search key
  } cell_cmd_t;

endpackage

[rtl/core/oqdk_in_if.sv]
`timescale 1ns / 1ps

interface oqdk_in_if;
  import oqdk_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [KEY_BITS-1:0] key;
  logic [TAG_BITS-1:0] name_tag;
  logic                background;

  modport source (output valid, opcode, key, name_tag, background, input ready);
  modport sink   (input valid, opcode, key, name_tag, background, output ready);
endinterface

[rtl/core/oqdk_out_if.sv]
`timescale 1ns / 1ps

interface oqdk_out_if;
  import oqdk_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic                found;
  logic [TAG_BITS-1:0] found_tag;
  logic                found_background;
  logic                is_empty;
  logic [CNT_W-1:0]    occupancy;

  modport source (output valid, status, found, found_tag, found_background, is_empty,
                  occupancy, input ready);
  modport sink   (input valid, status, found, found_tag, found_background, is_empty,
                  occupancy, output ready);
endinterface

[rtl/core/ordered_queue_delete_by_key_core.sv]
`timescale 1ns / 1ps

// ordered queue with keyed delete, built as a row of storage cells
// in_ch: one word per operation (opcode, key, name_tag, background)
//   enqueue appends at the tail, dequeue drops the head, delete removes the
//   oldest entry with a matching key and closes the gap, lookup reports it
// out_ch: exactly one result word per operation, in order
//   status, found flag with the matched tag and flag, is_empty, occupancy
// steps: an operation goes through accept, compare in every cell, then
//   commit; the match priority and the found data ripple cell to cell
//   from the head within the commit cycle, and shifts go one slot per cell
// a new operation is accepted only once the previous one has committed
// the result sits in an output register; the next word is accepted while
//   it waits, but the commit of that word holds until the register frees
// reset: count cleared, queue empty, no result pending; entry contents are
//   left as they are and never read beyond the count
// a stalled receiver holds the result word stable and blocks the commit

module ordered_queue_delete_by_key_core (
  input logic clk,
  input logic rst_n,
  oqdk_in_if.sink    in_ch,
  oqdk_out_if.source out_ch
);
  import oqdk_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // latched operation word
  logic [1:0] op_r;
  entry_t     wr_r;

  // output register
  logic                out_valid_r;
  logic [1:0]          status_r, status_nxt;
  logic                found_r;
  logic [TAG_BITS-1:0] found_tag_r;
  logic                found_bg_r;
  logic [CNT_W-1:0]    occ_r;

  cell_cmd_t  cmd;
  logic       commit;
  logic       empty_q, full_q;
  logic       find_op;

  // chain wiring: index 0 is the head
  logic   [DEPTH:0]   seen;
  fnd_t   [DEPTH:0]   fnd;
  entry_t [DEPTH-1:0] ent;
  entry_t [DEPTH-1:0] nbr;
  logic   [DEPTH-1:0] valid_v, tail_v;

  assign in_ch.ready = (state_r == S_IDLE);
  assign commit = (state_r == S_APPLY) && (!out_valid_r || out_ch.ready);

  assign empty_q = (count_r == '0);
  assign full_q  = (count_r == CNT_W'(DEPTH));
  assign find_op = (op_r == OP_DEL) || (op_r == OP_LOOK);

  always_comb begin
    cmd.cmp       = (state_r == S_CMP);
    cmd.apply     = commit;
    cmd.enq_wr    = (op_r == OP_ENQ) && !full_q;
    cmd.shift_all = (op_r == OP_DEQ) && !empty_q;
    cmd.shift_del = (op_r == OP_DEL);
    cmd.wr        = wr_r;
  end

  assign seen[0] = 1'b0;
  assign fnd[0]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid_v[i] = (count_r > CNT_W'(i));
    assign tail_v[i]  = (count_r == CNT_W'(i));
    // the youngest cell takes don't-care data on a shift, it is beyond the count
    if (i == DEPTH - 1) begin : g_last
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i] = ent[i+1];
    end

    oqdk_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .valid    (valid_v[i]),
      .is_tail  (tail_v[i]),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .fnd_in   (fnd[i]),
      .fnd_out  (fnd[i+1]),
      .nbr_in   (nbr[i]),
      .ent_out  (ent[i])
    );
  end

  // status and count after this operation
  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    if (op_r == OP_ENQ) begin
      if (full_q) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (empty_q) begin
      status_nxt = ST_EMPTY;
    end else if (op_r == OP_DEQ) begin
      count_nxt = count_r - 1'b1;
    end else if (!fnd[DEPTH].hit) begin
      status_nxt = ST_MISSING;
    end else if (op_r == OP_DEL) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_APPLY;
      S_APPLY: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r       <= in_ch.opcode;
      wr_r.key   <= in_ch.key;
      wr_r.tag   <= in_ch.name_tag;
      wr_r.bg    <= in_ch.background;
    end
    if (commit) begin
      status_r    <= status_nxt;
      found_r     <= find_op && fnd[DEPTH].hit;
      found_tag_r <= (find_op && fnd[DEPTH].hit) ? fnd[DEPTH].tag : '0;
      found_bg_r  <= find_op && fnd[DEPTH].hit && fnd[DEPTH].bg;
      occ_r       <= count_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.found            = found_r;
  assign out_ch.found_tag        = found_tag_r;
  assign out_ch.found_background = found_bg_r;
  assign out_ch.is_empty         = (occ_r == '0);
  assign out_ch.occupancy        = occ_r;

endmodule

[rtl/core/oqdk_cell.sv]
`timescale 1ns / 1ps

module oqdk_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  oqdk_pkg::cell_cmd_t cmd,
  input  logic               valid,     // slot index below the count
  input  logic               is_tail,   // slot index equals the count
  input  logic               seen_in,   // an older cell matched
  output logic               seen_out,
  input  oqdk_pkg::fnd_t     fnd_in,
  output oqdk_pkg::fnd_t     fnd_out,
  input  oqdk_pkg::entry_t   nbr_in,    // entry of the younger neighbor
  output oqdk_pkg::entry_t   ent_out
);
  import oqdk_pkg::*;

  entry_t ent_r;
  logic   match_r;
  logic   first;

  assign first    = match_r & ~seen_in;
  assign seen_out = seen_in | match_r;
  assign ent_out  = ent_r;

  always_comb begin
    fnd_out = fnd_in;
    if (first) begin
      fnd_out.hit = 1'b1;
      fnd_out.tag = ent_r.tag;
      fnd_out.bg  = ent_r.bg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (cmd.cmp) begin
      match_r <= valid && (ent_r.key == cmd.wr.key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (cmd.enq_wr && is_tail) begin
        ent_r <= cmd.wr;
      end else if (cmd.shift_all || (cmd.shift_del && seen_out)) begin
        ent_r <= nbr_in;
      end
    end
  end

endmodule
